>>> hw/rtl/cbbss_pkg.sv
// Shared types and constants for the circular bit buffer with sync search.
// No dependencies; used by circular_bit_buffer_sync_search_unit.
package cbbss_pkg;

  localparam int BufLenDefault     = 148;
  localparam int MaxPatternDefault = 64;

  // search start: max(0, (len_buf - SearchGuard - len) / 2 - SearchBack)
  localparam int SearchGuard = 8;
  localparam int SearchBack  = 3;

  localparam logic [1:0] ModePush   = 2'd0;
  localparam logic [1:0] ModeSearch = 2'd1;
  localparam logic [1:0] ModeRead   = 2'd2;

  localparam logic [1:0] KindPush   = 2'd0;
  localparam logic [1:0] KindSearch = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;

  localparam logic [1:0] RegSyncPattern   = 2'd0;
  localparam logic [1:0] RegPatternLength = 2'd1;
  localparam logic [1:0] RegBarrierPos    = 2'd2;
  localparam logic [1:0] RegNotifyEnable  = 2'd3;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSrchRd,
    StSrchChk,
    StSrchDone,
    StRdMod,
    StRdRd,
    StRdChk
  } state_e;

endpackage

>>> hw/rtl/circular_bit_buffer_sync_search_unit.sv
// Circular bit buffer with sync-word search and read-out.
// Depends on cbbss_pkg.
//
// Usage: requests enter on in_valid_i/in_stall_o, results leave on
// out_valid_o/out_stall_i; a request is taken when valid is high and stall
// low. Registers are written on cfg_valid_i/cfg_ready_o (always ready).
// A push stores one bit and gives one result in the output register in the
// next cycle; pushes are taken every cycle while the output register drains.
// A search streams the ring through a window register, one bit at a time
// from the bit memory, reading it in StSrchRd and shifting it in in StSrchChk.
// A read-out first brings the start offset into range by repeated
// add/subtract of BufLen, then streams BufLen bits, reading each in StRdRd
// and collecting it in StRdChk, giving ceil(BufLen/64) words.
// Search and read-out requests block the input until their last result
// is in the output register. After reset the bit memory is cleared
// address by address, during which no request is taken. A stalled output holds
// its result and the sequencer waits on it.
module circular_bit_buffer_sync_search_unit #(
  parameter int BufLen     = cbbss_pkg::BufLenDefault,
  parameter int MaxPattern = cbbss_pkg::MaxPatternDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic               bit_value_i,
  input  logic signed [11:0] start_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic               barrier_hit_o,
  output logic               found_o,
  output logic [8:0]         match_offset_o,
  output logic [63:0]        data_word_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int AW  = $clog2(BufLen);
  localparam int OW  = AW + 1;
  localparam int PLW = $clog2(MaxPattern + 1);
  localparam int DW  = ((AW > PLW) ? AW : PLW) + 2;
  localparam int RW  = 13;
  localparam int CW  = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] LastPos = AW'(BufLen - 1);

  cbbss_pkg::state_e state_q, state_d;

  logic [63:0]           sync_pattern_q;
  logic [6:0]            pattern_length_q;
  logic [7:0]            barrier_position_q;
  logic                  notify_enable_q;

  logic                  mem_q [BufLen];
  logic                  rdata_q;
  logic                  mem_we, mem_wdata, mem_re;
  logic [AW-1:0]         mem_waddr;

  logic [AW-1:0]         wpos_q, wpos_d;
  logic [AW-1:0]         rpos_q, rpos_d;
  logic [OW-1:0]         off_q, off_d, end_q, end_d;
  logic [PLW-1:0]        len_q, len_d, fill_q, fill_d;
  logic [MaxPattern-1:0] win_q, win_d, pat_q, pat_d, mask_q, mask_d;
  logic signed [RW-1:0]  rmod_q, rmod_d;
  logic [63:0]           word_q, word_d;
  logic [5:0]            bidx_q, bidx_d;
  logic [AW-1:0]         total_q, total_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            kind_q, kind_d;
  logic                  barrier_hit_q, barrier_hit_d;
  logic                  found_q, found_d;
  logic [8:0]            match_offset_q, match_offset_d;
  logic [63:0]           data_word_q, data_word_d;
  logic                  last_q, last_d;

  logic                  out_free, in_take;
  logic [PLW-1:0]        len_eff, shamt, fill_nx;
  logic signed [DW-1:0]  diff_s;
  logic [DW-2:0]         half;
  logic [OW-1:0]         init_off;
  logic [AW-1:0]         wpos_nx, rpos_nx;
  logic [MaxPattern-1:0] win_nx;
  logic [63:0]           word_nx;
  logic                  win_match, word_emit;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == cbbss_pkg::StIdle) && out_free);
  assign in_take     = in_valid_i && !in_stall_o;

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign barrier_hit_o  = barrier_hit_q;
  assign found_o        = found_q;
  assign match_offset_o = match_offset_q;
  assign data_word_o    = data_word_q;
  assign last_o         = last_q;

  // search setup from the registers
  always_comb begin
    len_eff  = (pattern_length_q > 7'(MaxPattern)) ? PLW'(MaxPattern) : PLW'(pattern_length_q);
    shamt    = PLW'(MaxPattern) - len_eff;
    diff_s   = $signed(DW'(BufLen - cbbss_pkg::SearchGuard)) -
               $signed({{(DW-PLW){1'b0}}, len_eff});
    half     = diff_s[DW-1:1];
    init_off = (diff_s >= $signed(DW'(2 * cbbss_pkg::SearchBack))) ?
               (OW'(half) - OW'(cbbss_pkg::SearchBack)) : '0;
  end

  assign wpos_nx = (wpos_q == LastPos) ? '0 : wpos_q + AW'(1);
  assign rpos_nx = (rpos_q == LastPos) ? '0 : rpos_q + AW'(1);
  assign win_nx  = (win_q >> 1) | (MaxPattern'(rdata_q) << (MaxPattern - 1));
  assign fill_nx = (fill_q == len_q) ? fill_q : fill_q + PLW'(1);
  assign win_match = (((win_nx ^ pat_q) & mask_q) == '0);
  assign word_nx   = word_q | (64'(rdata_q) << bidx_q);
  assign word_emit = (bidx_q == 6'd63) || (total_q == LastPos);

  always_comb begin
    state_d        = state_q;
    wpos_d         = wpos_q;
    rpos_d         = rpos_q;
    off_d          = off_q;
    end_d          = end_q;
    len_d          = len_q;
    fill_d         = fill_q;
    win_d          = win_q;
    pat_d          = pat_q;
    mask_d         = mask_q;
    rmod_d         = rmod_q;
    word_d         = word_q;
    bidx_d         = bidx_q;
    total_d        = total_q;
    out_valid_d    = out_valid_q && out_stall_i;
    kind_d         = kind_q;
    barrier_hit_d  = barrier_hit_q;
    found_d        = found_q;
    match_offset_d = match_offset_q;
    data_word_d    = data_word_q;
    last_d         = last_q;
    mem_we         = 1'b0;
    mem_waddr      = wpos_q;
    mem_wdata      = 1'b0;
    mem_re         = 1'b0;

    case (state_q)
      cbbss_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = rpos_q;
        rpos_d    = rpos_nx;
        if (rpos_q == LastPos) begin
          state_d = cbbss_pkg::StIdle;
        end
      end
      cbbss_pkg::StIdle: begin
        if (in_take) begin
          case (mode_i)
            cbbss_pkg::ModePush: begin
              mem_we         = 1'b1;
              mem_wdata      = bit_value_i;
              wpos_d         = wpos_nx;
              out_valid_d    = 1'b1;
              kind_d         = cbbss_pkg::KindPush;
              barrier_hit_d  = notify_enable_q &&
                               (CW'(wpos_nx) == CW'(barrier_position_q));
              found_d        = 1'b0;
              match_offset_d = '0;
              data_word_d    = '0;
              last_d         = 1'b1;
            end
            cbbss_pkg::ModeSearch: begin
              len_d  = len_eff;
              fill_d = '0;
              pat_d  = sync_pattern_q[MaxPattern-1:0] << shamt;
              mask_d = {MaxPattern{1'b1}} << shamt;
              off_d  = init_off;
              end_d  = init_off + OW'(BufLen - 1);
              rpos_d = init_off[AW-1:0];
              if (len_eff == '0) begin
                found_d = 1'b1;
                state_d = cbbss_pkg::StSrchDone;
              end else begin
                found_d = 1'b0;
                state_d = cbbss_pkg::StSrchRd;
              end
            end
            cbbss_pkg::ModeRead: begin
              rmod_d  = RW'(start_offset_i);
              word_d  = '0;
              bidx_d  = '0;
              total_d = '0;
              state_d = cbbss_pkg::StRdMod;
            end
            default: begin
            end
          endcase
        end
      end
      cbbss_pkg::StSrchRd: begin
        mem_re  = 1'b1;
        rpos_d  = rpos_nx;
        state_d = cbbss_pkg::StSrchChk;
      end
      cbbss_pkg::StSrchChk: begin
        win_d   = win_nx;
        fill_d  = fill_nx;
        state_d = cbbss_pkg::StSrchRd;
        if (fill_nx == len_q) begin
          if (win_match) begin
            found_d = 1'b1;
            state_d = cbbss_pkg::StSrchDone;
          end else if (off_q == end_q) begin
            found_d = 1'b0;
            off_d   = '0;
            state_d = cbbss_pkg::StSrchDone;
          end else begin
            off_d = off_q + OW'(1);
          end
        end
      end
      cbbss_pkg::StSrchDone: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          kind_d         = cbbss_pkg::KindSearch;
          barrier_hit_d  = 1'b0;
          match_offset_d = 9'(off_q);
          data_word_d    = '0;
          last_d         = 1'b1;
          state_d        = cbbss_pkg::StIdle;
        end
      end
      cbbss_pkg::StRdMod: begin
        if (rmod_q < 0) begin
          rmod_d = rmod_q + RW'(BufLen);
        end else if (rmod_q >= $signed(RW'(BufLen))) begin
          rmod_d = rmod_q - RW'(BufLen);
        end else begin
          rpos_d  = rmod_q[AW-1:0];
          state_d = cbbss_pkg::StRdRd;
        end
      end
      cbbss_pkg::StRdRd: begin
        mem_re  = 1'b1;
        rpos_d  = rpos_nx;
        state_d = cbbss_pkg::StRdChk;
      end
      cbbss_pkg::StRdChk: begin
        if (!word_emit) begin
          word_d  = word_nx;
          bidx_d  = bidx_q + 6'd1;
          total_d = total_q + AW'(1);
          state_d = cbbss_pkg::StRdRd;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          kind_d         = cbbss_pkg::KindRead;
          barrier_hit_d  = 1'b0;
          found_d        = 1'b0;
          match_offset_d = '0;
          data_word_d    = word_nx;
          last_d         = (total_q == LastPos);
          word_d         = '0;
          bidx_d         = '0;
          total_d        = total_q + AW'(1);
          state_d        = (total_q == LastPos) ? cbbss_pkg::StIdle : cbbss_pkg::StRdRd;
        end
      end
      default: begin
        state_d = cbbss_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= cbbss_pkg::StClear;
      wpos_q             <= '0;
      rpos_q             <= '0;
      out_valid_q        <= 1'b0;
      sync_pattern_q     <= '0;
      pattern_length_q   <= 7'd1;
      barrier_position_q <= '0;
      notify_enable_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cbbss_pkg::RegSyncPattern:   sync_pattern_q     <= cfg_data_i;
          cbbss_pkg::RegPatternLength: pattern_length_q   <= cfg_data_i[6:0];
          cbbss_pkg::RegBarrierPos:    barrier_position_q <= cfg_data_i[7:0];
          cbbss_pkg::RegNotifyEnable:  notify_enable_q    <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q          <= off_d;
    end_q          <= end_d;
    len_q          <= len_d;
    fill_q         <= fill_d;
    win_q          <= win_d;
    pat_q          <= pat_d;
    mask_q         <= mask_d;
    rmod_q         <= rmod_d;
    word_q         <= word_d;
    bidx_q         <= bidx_d;
    total_q        <= total_d;
    kind_q         <= kind_d;
    barrier_hit_q  <= barrier_hit_d;
    found_q        <= found_d;
    match_offset_q <= match_offset_d;
    data_word_q    <= data_word_d;
    last_q         <= last_d;
  end

  // bit memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rpos_q];
    end
  end

endmodule
